[src/tbh_pkg.sv]
// Shared types and constants for the take-back-half velocity controller.
package tbh_pkg;

   localparam int DriveW = 25;
   localparam int RpmW   = 16;
   localparam int NumW   = 47;
   localparam int DenW   = 48;
   localparam int QuoW   = 15;
   localparam int ProdW  = 33;

   localparam logic [DriveW-1:0] DRIVE_ONE  = 25'd16777216;
   localparam logic [31:0]       DRIVE_HALF = 32'd8388608;
   localparam logic [15:0]       RPM_SCALE  = 16'd60000;
   localparam logic [RpmW-1:0]   RPM_LIMIT  = 16'sd32767;

   localparam logic [1:0] REG_GAIN  = 2'd0;
   localparam logic [1:0] REG_TICKS = 2'd1;
   localparam logic [1:0] REG_POWER = 2'd2;

   localparam logic [15:0] GAIN_RESET  = 16'd4194;
   localparam logic [15:0] TICKS_RESET = 16'd360;
   localparam logic [6:0]  POWER_RESET = 7'd127;

   typedef struct packed {
      logic load;
      logic target;
      logic measure;
      logic saturate;
      logic div_init;
      logic div_step;
      logic err_mul;
      logic drive;
      logic motor;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic is_target;
      logic skip;
      logic sat;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

[src/take_back_half_velocity_controller_core.sv]
// A set-target transaction skips the measurement; a sample transaction runs the 15-step
// restoring divider unless the time or tick count is zero or the result saturates.
// Throughput: one transaction at a time; a new transaction is taken while a finished result waits.
// Reset: synchronous; clears the state machine and persistent controller state and loads
// register defaults; the datapath's working registers are not reset.
module take_back_half_velocity_controller_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // action
   input  logic [103:0] req_tdata,   // encoder_count, time_ms, target_rpm, drive estimate
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata    // motor_command, measured_rpm, zero_crossed
);
   import tbh_pkg::*;

   cmd_type    cmd;
   status_type status;

   tbh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tbh_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

[src/tbh_ctrl.sv]
// Sequencing state machine for the take-back-half controller.
module tbh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  tbh_pkg::status_type status,
   output tbh_pkg::cmd_type    cmd
);
   import tbh_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TGT  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_ERR  = 3'd5;
   localparam logic [2:0] S_DRV  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       mot_ff, mot_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      mot_in   = 1'b0;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_TGT;
            end
         end
         S_TGT: begin
            if (status.is_target) begin
               cmd.target = 1'b1;
               mot_in     = 1'b1;
               state_in   = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.measure = 1'b1;
            state_in    = S_CHK;
         end
         S_CHK: begin
            if (status.skip) begin
               state_in = S_ERR;
            end else if (status.sat) begin
               cmd.saturate = 1'b1;
               state_in     = S_ERR;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            cmd.err_mul = 1'b1;
            state_in    = S_DRV;
         end
         S_DRV: begin
            cmd.drive = 1'b1;
            mot_in    = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (mot_ff) begin
               cmd.motor = 1'b1;
            end else if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mot_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         mot_ff   <= mot_in;
      end
   end

endmodule

[src/tbh_datapath.sv]
// Datapath: speed measurement, divider, drive update and motor scaling.
module tbh_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic                req_tuser,
   input  logic [103:0]        req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   input  tbh_pkg::cmd_type    cmd,
   output tbh_pkg::status_type status
);
   import tbh_pkg::*;

   logic [15:0] gain_ff, gain_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [6:0]  power_ff, power_in;

   logic              act_ff, act_in;
   logic [31:0]       enc_ff, enc_in;
   logic [31:0]       tms_ff, tms_in;
   logic [14:0]       tgt_req_ff, tgt_req_in;
   logic [DriveW-1:0] pd_ff, pd_in;

   logic [31:0]       prev_enc_ff, prev_enc_in;
   logic [31:0]       prev_tms_ff, prev_tms_in;
   logic [RpmW-1:0]   vel_ff, vel_in;
   logic [14:0]       tgt_ff, tgt_in;
   logic [1:0]        sign_ff, sign_in;
   logic [DriveW-1:0] drive_ff, drive_in;
   logic [DriveW-1:0] held_ff, held_in;
   logic [DriveW-1:0] olp_ff, olp_in;
   logic              pend_ff, pend_in;

   logic              neg_ff, neg_in;
   logic              skip_ff, skip_in;
   logic [NumW-1:0]   rem_ff, rem_in;
   logic [62:0]       dsh_ff, dsh_in;
   logic [DenW-1:0]   den_ff, den_in;
   logic [QuoW-1:0]   quo_ff, quo_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [ProdW-1:0]  prod_ff, prod_in;
   logic [16:0]       err_ff, err_in;
   logic              crossed_ff, crossed_in;
   logic [31:0]       mprod_ff, mprod_in;

   logic              rv_ff, rv_in;
   logic [23:0]       rd_ff, rd_in;

   logic [31:0]       denc, dms, mag;
   logic [16:0]       err_c;
   logic [1:0]        sgn_c;
   logic [34:0]       dsum;
   logic [DriveW-1:0] dclip;
   logic [DriveW:0]   mean;
   logic [62:0]       rem_ext;
   logic [QuoW-1:0]   quo_nx;
   logic [31:0]       mround;

   assign status.is_target = act_ff;
   assign status.skip      = skip_ff;
   assign status.sat       = {16'd0, rem_ff} >= {den_ff, 15'd0};
   assign status.div_last  = (cnt_ff == 4'd0);
   assign status.out_free  = !rv_ff || rsp_tready;

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   always_comb begin
      denc    = req_tdata[31:0];
      dms     = 32'd0;
      mag     = 32'd0;
      err_c   = 17'd0;
      sgn_c   = 2'd0;
      dsum    = 35'd0;
      dclip   = '0;
      mean    = '0;
      rem_ext = 63'd0;
      quo_nx  = quo_ff;
      mround  = 32'd0;

      gain_in  = gain_ff;
      ticks_in = ticks_ff;
      power_in = power_ff;
      if (csr_we) begin
         case (csr_index)
            REG_GAIN:  gain_in  = csr_data;
            REG_TICKS: ticks_in = csr_data;
            REG_POWER: power_in = csr_data[6:0];
            default: ;
         endcase
      end

      act_in     = act_ff;
      enc_in     = enc_ff;
      tms_in     = tms_ff;
      tgt_req_in = tgt_req_ff;
      pd_in      = pd_ff;
      prev_enc_in = prev_enc_ff;
      prev_tms_in = prev_tms_ff;
      vel_in   = vel_ff;
      tgt_in   = tgt_ff;
      sign_in  = sign_ff;
      drive_in = drive_ff;
      held_in  = held_ff;
      olp_in   = olp_ff;
      pend_in  = pend_ff;
      neg_in   = neg_ff;
      skip_in  = skip_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      err_in   = err_ff;
      crossed_in = crossed_ff;
      mprod_in = mprod_ff;
      rv_in    = rv_ff;
      rd_in    = rd_ff;

      if (cmd.load) begin
         act_in     = req_tuser;
         enc_in     = req_tdata[31:0];
         tms_in     = req_tdata[63:32];
         tgt_req_in = req_tdata[78:64];
         pd_in      = req_tdata[103:79];
         crossed_in = 1'b0;
      end

      if (cmd.target) begin
         tgt_in  = tgt_req_ff;
         err_c   = {2'b00, tgt_req_ff} - {vel_ff[15], vel_ff};
         sign_in = (err_c == 17'd0) ? 2'b00 : (err_c[16] ? 2'b11 : 2'b01);
         olp_in  = (pd_ff > DRIVE_ONE) ? DRIVE_ONE : pd_ff;
         pend_in = 1'b1;
         held_in = '0;
      end

      if (cmd.measure) begin
         denc        = enc_ff - prev_enc_ff;
         dms         = tms_ff - prev_tms_ff;
         mag         = denc[31] ? (~denc + 32'd1) : denc;
         neg_in      = denc[31];
         rem_in      = NumW'({15'd0, mag} * {31'd0, RPM_SCALE});
         den_in      = DenW'({16'd0, dms} * {32'd0, ticks_ff});
         skip_in     = (dms == 32'd0) || (ticks_ff == 16'd0);
         prev_enc_in = enc_ff;
         prev_tms_in = tms_ff;
      end

      if (cmd.saturate) begin
         vel_in = neg_ff ? -RPM_LIMIT : RPM_LIMIT;
      end

      if (cmd.div_init) begin
         dsh_in = {den_ff, 15'd0} >> 1;
         quo_in = '0;
         cnt_in = 4'd14;
      end

      if (cmd.div_step) begin
         rem_ext = {16'd0, rem_ff};
         quo_nx  = {quo_ff[QuoW-2:0], 1'b0};
         if (rem_ext >= dsh_ff) begin
            rem_in    = NumW'(rem_ext - dsh_ff);
            quo_nx[0] = 1'b1;
         end
         quo_in = quo_nx;
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            vel_in = neg_ff ? -{1'b0, quo_nx} : {1'b0, quo_nx};
         end
      end

      if (cmd.err_mul) begin
         err_c   = {2'b00, tgt_ff} - {vel_ff[15], vel_ff};
         err_in  = err_c;
         prod_in = ProdW'($signed(err_c) * $signed({1'b0, gain_ff}));
      end

      if (cmd.drive) begin
         dsum  = {10'd0, drive_ff} + {{2{prod_ff[ProdW-1]}}, prod_ff};
         if (dsum[34]) begin
            dclip = '0;
         end else if (dsum > {10'd0, DRIVE_ONE}) begin
            dclip = DRIVE_ONE;
         end else begin
            dclip = dsum[DriveW-1:0];
         end
         sgn_c = (err_ff == 17'd0) ? 2'b00 : (err_ff[16] ? 2'b11 : 2'b01);
         if (sgn_c != sign_ff) begin
            if (pend_ff) begin
               dclip   = olp_ff;
               pend_in = 1'b0;
            end else begin
               mean  = {1'b0, dclip} + {1'b0, held_ff};
               dclip = mean[DriveW:1];
            end
            held_in    = dclip;
            crossed_in = 1'b1;
         end
         drive_in = dclip;
         sign_in  = sgn_c;
      end

      if (cmd.motor) begin
         mprod_in = {7'd0, drive_ff} * {25'd0, power_ff};
      end

      if (cmd.out_load) begin
         mround = mprod_ff + DRIVE_HALF;
         rv_in  = 1'b1;
         rd_in  = {crossed_ff, vel_ff, mround[30:24]};
      end else if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= GAIN_RESET;
         ticks_ff    <= TICKS_RESET;
         power_ff    <= POWER_RESET;
         prev_enc_ff <= '0;
         prev_tms_ff <= '0;
         vel_ff      <= '0;
         tgt_ff      <= '0;
         sign_ff     <= '0;
         drive_ff    <= '0;
         held_ff     <= '0;
         olp_ff      <= '0;
         pend_ff     <= 1'b0;
         rv_ff       <= 1'b0;
      end else begin
         gain_ff     <= gain_in;
         ticks_ff    <= ticks_in;
         power_ff    <= power_in;
         prev_enc_ff <= prev_enc_in;
         prev_tms_ff <= prev_tms_in;
         vel_ff      <= vel_in;
         tgt_ff      <= tgt_in;
         sign_ff     <= sign_in;
         drive_ff    <= drive_in;
         held_ff     <= held_in;
         olp_ff      <= olp_in;
         pend_ff     <= pend_in;
         rv_ff       <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      enc_ff     <= enc_in;
      tms_ff     <= tms_in;
      tgt_req_ff <= tgt_req_in;
      pd_ff      <= pd_in;
      neg_ff     <= neg_in;
      skip_ff    <= skip_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      den_ff     <= den_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      prod_ff    <= prod_in;
      err_ff     <= err_in;
      crossed_ff <= crossed_in;
      mprod_ff   <= mprod_in;
      rd_ff      <= rd_in;
   end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the take-back-half velocity controller core.
module tb_top;
   import tbh_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic        action;
      logic [24:0] pd;
      logic [14:0] tgt;
      logic [31:0] tms;
      logic [31:0] enc;
   } cmd_item_type;

   typedef struct packed {
      logic        crossed;
      logic [15:0] rpm;
      logic [6:0]  motor;
   } drive_result_type;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [15:0]  csr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic         req_tuser;
   logic [103:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [23:0]  rsp_tdata;

   take_back_half_velocity_controller_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // controller shadow state
   logic [15:0] gain_q, ticks_q;
   logic [6:0]  power_q;
   logic [31:0] prev_enc, prev_tms;
   logic signed [31:0] vel, tgt_vel, err_sign;
   longint drive_q, held_q, open_loop_q;
   logic first_pend;

   cmd_item_type     pending_cmds[$];
   drive_result_type expected_results[$];
   int errors, sent, received, crossings, idle_cycles;
   int send_idle_pct, recv_stall_pct, hold_off;
   bit done_sending;

   function automatic int sgn(longint v);
      return (v > 0) - (v < 0);
   endfunction

   function automatic drive_result_type predict_drive(cmd_item_type c);
      drive_result_type r;
      longint err, d, mag, den, q;
      logic [31:0] denc, dms;
      bit neg;
      int s;
      r.crossed = 1'b0;
      if (c.action) begin
         tgt_vel = c.tgt;
         err_sign = sgn(longint'(tgt_vel) - vel);
         open_loop_q = (c.pd > DRIVE_ONE) ? 16777216 : c.pd;
         first_pend = 1'b1;
         held_q = 0;
      end else begin
         denc = c.enc - prev_enc;
         dms = c.tms - prev_tms;
         prev_enc = c.enc;
         prev_tms = c.tms;
         if (dms != 0 && ticks_q != 0) begin
            neg = denc[31];
            mag = neg ? longint'({1'b0, -denc}) : longint'(denc);
            if (neg && mag == 0) mag = 64'h8000_0000;
            den = longint'(dms) * longint'(ticks_q);
            q = (mag * 60000) / den;
            if (q > 32767) q = 32767;
            vel = neg ? -q : q;
         end
         err = longint'(tgt_vel) - longint'(vel);
         d = drive_q + err * longint'(gain_q);
         if (d > 16777216) d = 16777216;
         if (d < 0) d = 0;
         s = sgn(err);
         if (s != err_sign) begin
            if (first_pend) begin
               d = open_loop_q;
               first_pend = 1'b0;
            end else begin
               d = (d + held_q) >>> 1;
            end
            held_q = d;
            r.crossed = 1'b1;
         end
         drive_q = d;
         err_sign = s;
      end
      r.motor = 7'((drive_q * longint'(power_q) + 8388608) >>> 24);
      r.rpm = vel[15:0];
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, received);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_results.push_back(predict_drive(cmd_item_type'({req_tuser, req_tdata})));
            sent++;
         end
         if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            {req_tuser, req_tdata} <= pending_cmds.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver readiness
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      drive_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         received++;
         if (expected_results.size() == 0) begin
            report("unexpected transaction", 0, 0);
         end else begin
            want = expected_results.pop_front();
            if (got.motor != want.motor) report("motor_command", got.motor, want.motor);
            if (got.rpm != want.rpm) report("measured_rpm", got.rpm, want.rpm);
            if (got.crossed != want.crossed)
               report("zero_crossed", got.crossed, want.crossed);
            if (want.crossed) crossings++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("[take_back_half_velocity_controller_core] ERROR");
         $finish;
      end
   end

   task automatic drain();
      while (pending_cmds.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_GAIN:  gain_q = val;
         REG_TICKS: ticks_q = val;
         REG_POWER: power_q = val[6:0];
         default: ;
      endcase
   endtask

   function automatic cmd_item_type target_cmd(logic [14:0] t, logic [24:0] p);
      cmd_item_type c;
      c = '0;
      c.action = 1'b1;
      c.tgt = t;
      c.pd = p;
      c.enc = $urandom;
      c.tms = $urandom;
      return c;
   endfunction

   function automatic cmd_item_type sample_cmd(logic [31:0] e, logic [31:0] t);
      cmd_item_type c;
      c = '0;
      c.enc = e;
      c.tms = t;
      c.tgt = 15'($urandom);
      c.pd = 25'($urandom);
      return c;
   endfunction

   // flywheel-like run: a target then samples, usually at a roughly steady speed, sometimes random
   task automatic queue_spinup(int n);
      logic [31:0] e, t;
      int step_e, r;
      e = $urandom;
      t = $urandom;
      r = $urandom_range(99);
      pending_cmds.push_back(target_cmd(15'($urandom_range(3000)),
                                        25'($urandom_range(16777216 + 100))));
      for (int i = 0; i < n; i++) begin
         if (r < 10) pending_cmds.push_back(sample_cmd($urandom, $urandom));
         else begin
            step_e = $urandom_range(400);
            if ($urandom_range(9) == 0) step_e = -step_e;
            e += step_e;
            t += $urandom_range(40);
            pending_cmds.push_back(sample_cmd(e, t));
         end
      end
   endtask

   task automatic run_phase(int n, int sidle, int rstall);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      while (n > 0) begin
         queue_spinup(8 + $urandom_range(20));
         n -= 20;
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_GAIN;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      hold_off = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      gain_q = GAIN_RESET;
      ticks_q = TICKS_RESET;
      power_q = POWER_RESET;
      prev_enc = 0; prev_tms = 0; vel = 0; tgt_vel = 0; err_sign = 0;
      drive_q = 0; held_q = 0; open_loop_q = 0; first_pend = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero elapsed time, wraparound, oversized predicted drive
      pending_cmds.push_back(sample_cmd(32'd0, 32'd0));
      pending_cmds.push_back(target_cmd(15'd32767, 25'h1FF_FFFF));
      pending_cmds.push_back(sample_cmd(32'h7FFF_FFFF, 32'd1));
      pending_cmds.push_back(sample_cmd(32'h8000_0000, 32'd2));
      pending_cmds.push_back(sample_cmd(32'h8000_0000, 32'd2));
      pending_cmds.push_back(sample_cmd(32'h8000_0100, 32'hFFFF_FFFF));
      pending_cmds.push_back(target_cmd(15'd0, 25'd16777216));
      pending_cmds.push_back(sample_cmd(32'h8000_0000, 32'h0000_0010));
      pending_cmds.push_back(sample_cmd(32'h8000_0200, 32'h0000_0030));
      pending_cmds.push_back(target_cmd(15'd1500, 25'd0));
      pending_cmds.push_back(sample_cmd(32'h8000_0400, 32'h0000_0050));
      pending_cmds.push_back(sample_cmd(32'h8000_0600, 32'h0000_0070));
      pending_cmds.push_back(sample_cmd(32'hFFFF_FFFF, 32'h8000_0000));
      pending_cmds.push_back(target_cmd(15'h5555, 25'h0AA_AAAA));
      pending_cmds.push_back(sample_cmd(32'h5555_5555, 32'hAAAA_AAAA));
      drain();

      run_phase(300, 0, 0);
      write_reg(REG_GAIN, 16'hFFFF);
      write_reg(REG_TICKS, 16'd1);
      write_reg(REG_POWER, 16'd0);
      write_reg(REG_UNUSED, 16'h1234);
      run_phase(200, 51, 0);
      write_reg(REG_GAIN, 16'd0);
      write_reg(REG_TICKS, 16'hFFFF);
      write_reg(REG_POWER, 16'd127);
      run_phase(200, 0, 51);
      write_reg(REG_TICKS, 16'd0);
      run_phase(60, 12, 12);
      write_reg(REG_GAIN, 16'd20000);
      write_reg(REG_TICKS, 16'd90);
      write_reg(REG_POWER, 16'd100);
      run_phase(300, 12, 12);

      // long receiver hold-off with the sender pushing
      write_reg(REG_GAIN, GAIN_RESET);
      write_reg(REG_TICKS, TICKS_RESET);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_spinup(40);
      @(posedge clock);
      hold_off <= 400;
      drain();
      run_phase(200, 0, 0);

      $display("sent %0d transactions, checked %0d results, %0d zero crossings",
               sent, received, crossings);
      $display("covered gain/ticks/power extremes, zero ticks and idle/stall mixes");
      if (errors == 0 && expected_results.size() == 0)
         $display("[take_back_half_velocity_controller_core] OK");
      else
         $display("[take_back_half_velocity_controller_core] ERROR");
      $finish;
   end
endmodule

[files.f]
src/tbh_pkg.sv
src/tbh_ctrl.sv
src/tbh_datapath.sv
src/take_back_half_velocity_controller_core.sv
verif/tb_top.sv
